>>> sv/single_wire_uart_8n1_defines.svh
// Assertion helpers shared by the checker files of this block
`ifndef SINGLE_WIRE_UART_8N1_DEFINES_SVH
`define SINGLE_WIRE_UART_8N1_DEFINES_SVH

// Property checked while reset is low
`define SWU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every edge, reset included
`define SWU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/swuart_pkg.sv
package swuart_pkg;

   // Shared phase encoding of the transmit and receive machines
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_START,
      PH_DATA,
      PH_STOP
   } phase_type;

   // Request function codes
   localparam logic [2:0] FUNC_TICK  = 3'd0;
   localparam logic [2:0] FUNC_PUSH  = 3'd1;
   localparam logic [2:0] FUNC_POP   = 3'd2;
   localparam logic [2:0] FUNC_START = 3'd3;
   localparam logic [2:0] FUNC_FLUSH = 3'd4;

   localparam int FUNC_W  = 3;
   localparam int BYTE_W  = 8;
   localparam int DELAY_W = 4;
   localparam int BITS_W  = 4;
   localparam int COUNT_W = 5;
   localparam int REQ_W   = 16;
   localparam int RSP_W   = 24;

   localparam logic [BITS_W-1:0]  DATA_BITS   = 4'd8;
   localparam logic [DELAY_W-1:0] DELAY_RESET = 4'd2;

endpackage

>>> sv/single_wire_uart_8n1.sv
// Half-duplex single-wire UART, 8N1, LSB first. Each request is one bit tick,
// a transmit push, a receive pop, a start-edge event or a flush, and yields
// exactly one response. A request is held in the input register, is
// applied to the UART state and rings there, and its status is captured in the
// response register; one request per clock is sustained while rsp_tready holds.
// The transmit and receive rings are memories with a registered read port; the
// head entry of each ring is prefetched every cycle, so a tick that loads a byte
// or a pop that returns one need not wait for the read. A ring holds DEPTH-1 bytes.
// csr_data sets the receive start delay in ticks (reset 2, zero acts as one).
module single_wire_uart_8n1 #(
   parameter int TX_DEPTH = 32,
   parameter int RX_DEPTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] data, [8] line_in, [15:9] zero
   input  logic [swuart_pkg::REQ_W-1:0]      req_tdata,
   // [2:0] func
   input  logic [swuart_pkg::FUNC_W-1:0]     req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] line_out, [8:1] rd_data, [9] rd_valid, [14:10] rx_count,
   // [15] tx_accepted, [16] tx_full, [17] tx_idle, [23:18] zero
   output logic [swuart_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [swuart_pkg::DELAY_W-1:0]    csr_data
);

   localparam int TX_PW = $clog2(TX_DEPTH);
   localparam int RX_PW = $clog2(RX_DEPTH);
   localparam int RX_FW = RX_PW + swuart_pkg::COUNT_W;

   function automatic logic [TX_PW-1:0] tx_next(input logic [TX_PW-1:0] p);
      return (p == TX_PW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [RX_PW-1:0] rx_next(input logic [RX_PW-1:0] p);
      return (p == RX_PW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Input register
   logic                              in_valid_ff;
   logic [swuart_pkg::FUNC_W-1:0]     in_func_ff;
   logic [swuart_pkg::BYTE_W-1:0]     in_data_ff;
   logic                              in_line_ff;

   // Configuration
   logic [swuart_pkg::DELAY_W-1:0]    rx_delay_ff;

   // Transmit state
   logic [swuart_pkg::BYTE_W-1:0]     tx_mem [TX_DEPTH];
   logic [swuart_pkg::BYTE_W-1:0]     tx_head_ff;
   logic [TX_PW-1:0]                  tx_wr_ff, tx_wr_in, tx_rd_ff, tx_rd_in;
   swuart_pkg::phase_type             tx_phase_ff, tx_phase_in;
   logic [swuart_pkg::BYTE_W-1:0]     tx_shift_ff, tx_shift_in;
   logic [swuart_pkg::BITS_W-1:0]     tx_bits_ff, tx_bits_in, tx_bits_inc;
   logic                              line_ff, line_in;

   // Receive state
   logic [swuart_pkg::BYTE_W-1:0]     rx_mem [RX_DEPTH];
   logic [swuart_pkg::BYTE_W-1:0]     rx_head_ff;
   logic [RX_PW-1:0]                  rx_wr_ff, rx_wr_in, rx_rd_ff, rx_rd_in;
   swuart_pkg::phase_type             rx_phase_ff, rx_phase_in;
   logic [swuart_pkg::BYTE_W-1:0]     rx_shift_ff, rx_shift_in;
   logic [swuart_pkg::BITS_W-1:0]     rx_bits_ff, rx_bits_in, rx_bits_inc;
   logic [swuart_pkg::DELAY_W-1:0]    rx_wait_ff, rx_wait_in, rx_wait_inc;

   // Response register
   logic                              rsp_valid_ff;
   logic [swuart_pkg::RSP_W-1:0]      rsp_data_ff, rsp_data_in;

   logic fire;
   logic do_tick, do_push, do_pop, do_start, do_flush;
   logic tx_empty, tx_full_cur, tx_load, push_ok;
   logic rx_full_cur, rx_store, pop_ok, rx_wait_done;
   logic [RX_FW-1:0] rx_fill;
   logic [swuart_pkg::BYTE_W-1:0] rd_data;
   logic tx_full_new, tx_idle_new;

   // Handshakes
   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // Request decode
   assign do_tick  = fire && (in_func_ff == swuart_pkg::FUNC_TICK);
   assign do_push  = fire && (in_func_ff == swuart_pkg::FUNC_PUSH);
   assign do_pop   = fire && (in_func_ff == swuart_pkg::FUNC_POP);
   assign do_start = fire && (in_func_ff == swuart_pkg::FUNC_START);
   assign do_flush = fire && (in_func_ff == swuart_pkg::FUNC_FLUSH);

   // Ring status before the request
   assign tx_empty    = (tx_wr_ff == tx_rd_ff);
   assign tx_full_cur = (tx_next(tx_wr_ff) == tx_rd_ff);
   assign rx_full_cur = (rx_next(rx_wr_ff) == rx_rd_ff);

   assign tx_load  = do_tick && (tx_phase_ff == swuart_pkg::PH_IDLE) && !tx_empty;
   assign push_ok  = do_push && !tx_full_cur;
   assign rx_store = do_tick && (rx_phase_ff == swuart_pkg::PH_STOP) && !rx_full_cur;
   assign pop_ok   = do_pop && (rx_wr_ff != rx_rd_ff);

   assign tx_bits_inc  = tx_bits_ff + 1'b1;
   assign rx_bits_inc  = rx_bits_ff + 1'b1;
   assign rx_wait_inc  = rx_wait_ff + 1'b1;
   assign rx_wait_done = (rx_wait_inc >= rx_delay_ff);

   // Ring pointers
   assign tx_rd_in = tx_load ? tx_next(tx_rd_ff) : tx_rd_ff;
   assign tx_wr_in = push_ok ? tx_next(tx_wr_ff) : tx_wr_ff;
   assign rx_wr_in = do_flush ? '0 : (rx_store ? rx_next(rx_wr_ff) : rx_wr_ff);
   assign rx_rd_in = do_flush ? '0 : (pop_ok ? rx_next(rx_rd_ff) : rx_rd_ff);

   // Transmit machine, next phase
   always_comb begin
      tx_phase_in = tx_phase_ff;
      if (do_tick) begin
         case (tx_phase_ff)
            swuart_pkg::PH_IDLE: begin
               if (!tx_empty) tx_phase_in = swuart_pkg::PH_START;
            end
            swuart_pkg::PH_START: tx_phase_in = swuart_pkg::PH_DATA;
            swuart_pkg::PH_DATA: begin
               if (tx_bits_inc >= swuart_pkg::DATA_BITS) tx_phase_in = swuart_pkg::PH_STOP;
            end
            default: tx_phase_in = swuart_pkg::PH_IDLE;
         endcase
      end
   end

   // Transmit machine, shifter and line level
   always_comb begin
      tx_shift_in = tx_shift_ff;
      tx_bits_in  = tx_bits_ff;
      line_in     = do_flush ? 1'b1 : line_ff;
      if (do_tick) begin
         case (tx_phase_ff)
            swuart_pkg::PH_IDLE: begin
               if (!tx_empty) begin
                  tx_shift_in = tx_head_ff;
                  tx_bits_in  = '0;
               end
            end
            swuart_pkg::PH_START: begin
               line_in    = 1'b0;
               tx_bits_in = '0;
            end
            swuart_pkg::PH_DATA: begin
               line_in    = tx_shift_ff[tx_bits_ff[2:0]];
               tx_bits_in = tx_bits_inc;
            end
            default: line_in = 1'b1;
         endcase
      end
   end

   // Receive machine, next phase
   always_comb begin
      rx_phase_in = rx_phase_ff;
      if (do_start && (rx_phase_ff == swuart_pkg::PH_IDLE)) begin
         rx_phase_in = swuart_pkg::PH_START;
      end else if (do_tick) begin
         case (rx_phase_ff)
            swuart_pkg::PH_IDLE:  rx_phase_in = swuart_pkg::PH_IDLE;
            swuart_pkg::PH_START: begin
               if (rx_wait_done) rx_phase_in = swuart_pkg::PH_DATA;
            end
            swuart_pkg::PH_DATA: begin
               if (rx_bits_inc >= swuart_pkg::DATA_BITS) rx_phase_in = swuart_pkg::PH_STOP;
            end
            default: rx_phase_in = swuart_pkg::PH_IDLE;
         endcase
      end
   end

   // Receive machine, delay counter and sampler
   always_comb begin
      rx_wait_in  = rx_wait_ff;
      rx_bits_in  = rx_bits_ff;
      rx_shift_in = rx_shift_ff;
      if (do_start && (rx_phase_ff == swuart_pkg::PH_IDLE)) begin
         rx_wait_in = '0;
      end else if (do_tick) begin
         case (rx_phase_ff)
            swuart_pkg::PH_IDLE: rx_wait_in = rx_wait_ff;
            swuart_pkg::PH_START: begin
               rx_wait_in = rx_wait_inc;
               if (rx_wait_done) begin
                  rx_wait_in  = '0;
                  rx_bits_in  = '0;
                  rx_shift_in = '0;
               end
            end
            swuart_pkg::PH_DATA: begin
               rx_shift_in[rx_bits_ff[2:0]] = rx_shift_ff[rx_bits_ff[2:0]] | in_line_ff;
               rx_bits_in = rx_bits_inc;
            end
            default: rx_wait_in = '0;
         endcase
      end
   end

   // Status after the request
   always_comb begin
      if (rx_wr_in >= rx_rd_in) begin
         rx_fill = RX_FW'(rx_wr_in) - RX_FW'(rx_rd_in);
      end else begin
         rx_fill = RX_FW'(rx_wr_in) + RX_FW'(RX_DEPTH) - RX_FW'(rx_rd_in);
      end
   end

   assign tx_full_new = (tx_next(tx_wr_in) == tx_rd_in);
   assign tx_idle_new = (tx_phase_in == swuart_pkg::PH_IDLE) && (tx_wr_in == tx_rd_in);
   assign rd_data     = pop_ok ? rx_head_ff : '0;

   assign rsp_data_in = {6'b0, tx_idle_new, tx_full_new, push_ok,
                         rx_fill[swuart_pkg::COUNT_W-1:0], pop_ok, rd_data, line_in};

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_func_ff <= req_tuser;
         in_data_ff <= req_tdata[7:0];
         in_line_ff <= req_tdata[8];
      end
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_delay_ff <= swuart_pkg::DELAY_RESET;
      end else if (csr_valid && csr_ready) begin
         rx_delay_ff <= csr_data;
      end
   end

   // UART state
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_wr_ff    <= '0;
         tx_rd_ff    <= '0;
         tx_phase_ff <= swuart_pkg::PH_IDLE;
         tx_shift_ff <= '0;
         tx_bits_ff  <= '0;
         line_ff     <= 1'b1;
         rx_wr_ff    <= '0;
         rx_rd_ff    <= '0;
         rx_phase_ff <= swuart_pkg::PH_IDLE;
         rx_shift_ff <= '0;
         rx_bits_ff  <= '0;
         rx_wait_ff  <= '0;
      end else begin
         tx_wr_ff    <= tx_wr_in;
         tx_rd_ff    <= tx_rd_in;
         tx_phase_ff <= tx_phase_in;
         tx_shift_ff <= tx_shift_in;
         tx_bits_ff  <= tx_bits_in;
         line_ff     <= line_in;
         rx_wr_ff    <= rx_wr_in;
         rx_rd_ff    <= rx_rd_in;
         rx_phase_ff <= rx_phase_in;
         rx_shift_ff <= rx_shift_in;
         rx_bits_ff  <= rx_bits_in;
         rx_wait_ff  <= rx_wait_in;
      end
   end

   // Transmit ring; head prefetched at the next read pointer, write forwarded
   always_ff @(posedge clock) begin
      if (push_ok) tx_mem[tx_wr_ff] <= in_data_ff;
      if (push_ok && (tx_wr_ff == tx_rd_in)) begin
         tx_head_ff <= in_data_ff;
      end else begin
         tx_head_ff <= tx_mem[tx_rd_in];
      end
   end

   // Receive ring; same prefetch scheme
   always_ff @(posedge clock) begin
      if (rx_store) rx_mem[rx_wr_ff] <= rx_shift_ff;
      if (rx_store && (rx_wr_ff == rx_rd_in)) begin
         rx_head_ff <= rx_shift_ff;
      end else begin
         rx_head_ff <= rx_mem[rx_rd_in];
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (fire) rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> sv/swuart_checker.sv
`include "single_wire_uart_8n1_defines.svh"

module swuart_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [swuart_pkg::RSP_W-1:0]      rsp_tdata
);

   // Stalled response holds
   `SWU_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

   // A stored push leaves the transmit side busy
   `SWU_ASSERT(a_push_busy, clock, reset, rsp_tvalid && rsp_tdata[15] |-> !rsp_tdata[17], "tx_idle set after stored push")

   // No byte returned means a zero data field
   `SWU_ASSERT(a_rd_zero, clock, reset, rsp_tvalid && !rsp_tdata[9] |-> rsp_tdata[8:1] == 8'd0, "rd_data nonzero without rd_valid")

   // Nothing comes out in the cycle after reset
   `SWU_ASSERT_ALWAYS(a_rst_quiet, clock, reset |=> !rsp_tvalid, "response valid right after reset")

endmodule

bind single_wire_uart_8n1 swuart_checker u_swuart_checker (.*);
